// File: rtl/lprd_pkg.sv
// lprd_pkg: shared types, constants and helper functions of the push-recovery
// displacement block. Used by every module under rtl/. No dependencies.
`timescale 1ns / 1ps

package lprd_pkg;

    // field widths
    localparam int VelW    = 16;
    localparam int ErrW    = VelW + 1;
    localparam int GainW   = 16;
    localparam int LimitW  = 15;
    localparam int ProdW   = 34;
    localparam int SumW    = ProdW + 1;
    localparam int DeltaW  = 16;
    localparam int StateW  = 32;
    localparam int NumLegs = 4;
    localparam int NumOut  = 2 * NumLegs;
    localparam int NumProd = 4;
    localparam int OutIdxW = $clog2(NumOut);
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 16;

    // decoupling queue
    localparam int QDepth  = 2;
    localparam int QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW   = $clog2(QDepth + 1);

    // +/-10.0 in Q5.11
    localparam logic signed [VelW-1:0] VelLimit = 16'sd20480;
    // shift amount of the rounding step from Q.25 to Q1.14
    localparam int RoundShift = 11;

    localparam logic [LimitW-1:0] LimitReset = 15'd1638;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_ENABLE        = 3'd0,
        REG_GAIN_LONG     = 3'd1,
        REG_GAIN_LAT      = 3'd2,
        REG_YAW_GAIN_LONG = 3'd3,
        REG_YAW_GAIN_LAT  = 3'd4,
        REG_LIMIT_LONG    = 3'd5,
        REG_LIMIT_LAT     = 3'd6,
        REG_FILTER_ALPHA  = 3'd7
    } lprd_reg_idx_t;

    typedef struct packed {
        logic [GainW-1:0]  gain_long;
        logic [GainW-1:0]  gain_lat;
        logic [GainW-1:0]  yaw_gain_long;
        logic [GainW-1:0]  yaw_gain_lat;
        logic [LimitW-1:0] limit_long;
        logic [LimitW-1:0] limit_lat;
        logic [GainW-1:0]  filter_alpha;
    } lprd_cfg_t;

    // one classified item: velocity errors and the flag after the range check
    typedef struct packed {
        logic signed [ErrW-1:0] e_long;
        logic signed [ErrW-1:0] e_lat;
        logic signed [ErrW-1:0] e_yaw;
        logic                   active;
    } lprd_entry_t;

    typedef struct packed {
        logic [QCntW-1:0] count;
        logic             full;
        logic             empty;
    } lprd_q_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lprd_back_status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PROD,
        B_FILT,
        B_DRAIN
    } lprd_back_state_t;

    // yaw term sign per output: x legs -,+,-,+ then y legs +,+,-,-
    function automatic logic yaw_negative(input logic [OutIdxW-1:0] idx);
        logic neg;
        case (idx)
            3'd0:    neg = 1'b1;
            3'd1:    neg = 1'b0;
            3'd2:    neg = 1'b1;
            3'd3:    neg = 1'b0;
            3'd4:    neg = 1'b0;
            3'd5:    neg = 1'b0;
            3'd6:    neg = 1'b1;
            3'd7:    neg = 1'b1;
            default: neg = 1'b0;
        endcase
        return neg;
    endfunction

endpackage

// File: rtl/lprd_front.sv
// lprd_front: configuration registers, range check of each input beat, sticky
// active flag and velocity error forming. Depends on lprd_pkg.
`timescale 1ns / 1ps

module lprd_front
    import lprd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CfgIdxW-1:0]        cfg_index,
    input  logic [CfgW-1:0]           cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VelW-1:0]    desired_vel_long,
    input  logic signed [VelW-1:0]    desired_vel_lat,
    input  logic signed [VelW-1:0]    desired_yaw_rate,
    input  logic signed [VelW-1:0]    measured_vel_long,
    input  logic signed [VelW-1:0]    measured_vel_lat,
    input  logic signed [VelW-1:0]    measured_yaw_rate,
    input  logic                      q_full,
    output logic                      push,
    output lprd_entry_t               push_data,
    output lprd_cfg_t                 cfg
);

    function automatic logic out_of_range(input logic signed [VelW-1:0] v);
        return (v > VelLimit) || (v < -VelLimit);
    endfunction

    lprd_cfg_t cfg_reg, cfg_next;
    logic      active_reg, active_next;
    logic      bad;
    logic      active_after;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;
    assign cfg      = cfg_reg;

    // range check over all six values
    always_comb
    begin
        bad = out_of_range(desired_vel_long)  || out_of_range(desired_vel_lat)  ||
              out_of_range(desired_yaw_rate)  || out_of_range(measured_vel_long) ||
              out_of_range(measured_vel_lat)  || out_of_range(measured_yaw_rate);
        active_after = active_reg && !bad;
    end

    // errors are measured minus desired, one bit wider
    always_comb
    begin
        push_data.e_long = ErrW'(measured_vel_long) - ErrW'(desired_vel_long);
        push_data.e_lat  = ErrW'(measured_vel_lat)  - ErrW'(desired_vel_lat);
        push_data.e_yaw  = ErrW'(measured_yaw_rate) - ErrW'(desired_yaw_rate);
        push_data.active = active_after;
    end

    // register writes; the enable write loads the flag
    always_comb
    begin
        cfg_next    = cfg_reg;
        active_next = active_reg;
        if (push)
        begin
            active_next = active_after;
        end
        if (cfg_we)
        begin
            case (lprd_reg_idx_t'(cfg_index))
                REG_ENABLE:        active_next           = cfg_data[0];
                REG_GAIN_LONG:     cfg_next.gain_long     = cfg_data;
                REG_GAIN_LAT:      cfg_next.gain_lat      = cfg_data;
                REG_YAW_GAIN_LONG: cfg_next.yaw_gain_long = cfg_data;
                REG_YAW_GAIN_LAT:  cfg_next.yaw_gain_lat  = cfg_data;
                REG_LIMIT_LONG:    cfg_next.limit_long    = cfg_data[LimitW-1:0];
                REG_LIMIT_LAT:     cfg_next.limit_lat     = cfg_data[LimitW-1:0];
                REG_FILTER_ALPHA:  cfg_next.filter_alpha  = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg            <= 1'b0;
            cfg_reg.gain_long     <= '0;
            cfg_reg.gain_lat      <= '0;
            cfg_reg.yaw_gain_long <= '0;
            cfg_reg.yaw_gain_lat  <= '0;
            cfg_reg.limit_long    <= LimitReset;
            cfg_reg.limit_lat     <= LimitReset;
            cfg_reg.filter_alpha  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cfg_reg    <= cfg_next;
        end
    end

endmodule

// File: rtl/lprd_queue.sv
// lprd_queue: short FIFO of classified items between front and back end.
// Depends on lprd_pkg.
`timescale 1ns / 1ps

module lprd_queue
    import lprd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lprd_entry_t    push_data,
    input  logic           pop,
    output lprd_entry_t    pop_data,
    output lprd_q_status_t status
);

    lprd_entry_t      mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;

    assign status.count = count_reg;
    assign status.full  = (count_reg == QCntW'(QDepth));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/lprd_back.sv
// lprd_back: gain products on a shared multiplier, then a three-stage
// delta / multiply / accumulate pipeline over the eight filter channels.
// Depends on lprd_pkg.
`timescale 1ns / 1ps

module lprd_back
    import lprd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lprd_cfg_t                      cfg,
    input  logic                           q_empty,
    input  lprd_entry_t                    q_data,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [NumOut-1:0][DeltaW-1:0]  dout,
    output logic                           active_out,
    output lprd_back_status_t              status
);

    lprd_back_state_t state_reg, state_next;
    logic [OutIdxW-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic prod_en, issue, done;

    lprd_entry_t ent_reg;
    logic signed [ProdW-1:0] prod_reg [NumProd];
    logic signed [ProdW-1:0] prod_next;

    // pipeline registers
    logic                     va_reg, vb_reg;
    logic [OutIdxW-1:0]       ka_reg, kb_reg;
    logic signed [DeltaW-1:0] d_reg, d_next;
    logic signed [49:0]       m1_reg, m1_next;
    logic signed [32:0]       m2_reg, m2_next;
    logic signed [StateW-1:0] st_reg [NumOut];
    logic [DeltaW-1:0]        dout_reg [NumOut];

    logic signed [StateW-1:0] f_next;
    logic [DeltaW-1:0]        o_next;

    assign out_valid   = out_valid_reg;
    assign active_out  = ent_reg.active;
    assign status.busy = (state_reg != B_IDLE);
    assign status.done = done;

    always_comb
    begin
        for (int i = 0; i < NumOut; i++)
        begin
            dout[i] = dout_reg[i];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && !out_valid_reg)
                begin
                    state_next = B_PROD;
                end
            end
            B_PROD:
            begin
                if (cnt_reg == OutIdxW'(NumProd - 1))
                begin
                    state_next = B_FILT;
                end
            end
            B_FILT:
            begin
                if (cnt_reg == OutIdxW'(NumOut - 1))
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                if (!va_reg && !vb_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop     = 1'b0;
        prod_en = 1'b0;
        issue   = 1'b0;
        done    = 1'b0;
        case (state_reg)
            B_IDLE:  pop     = !q_empty && !out_valid_reg;
            B_PROD:  prod_en = 1'b1;
            B_FILT:  issue   = 1'b1;
            B_DRAIN: done    = !va_reg && !vb_reg;
            default: ;
        endcase
    end

    // step counter and result valid
    always_comb
    begin
        cnt_next = cnt_reg;
        if (pop)
        begin
            cnt_next = '0;
        end
        else if (prod_en)
        begin
            cnt_next = (cnt_reg == OutIdxW'(NumProd - 1)) ? '0 : cnt_reg + 1'b1;
        end
        else if (issue)
        begin
            cnt_next = (cnt_reg == OutIdxW'(NumOut - 1)) ? '0 : cnt_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            va_reg        <= issue;
            vb_reg        <= va_reg;
        end
    end

    // shared gain multiplier: one product per step
    always_comb
    begin
        logic [GainW-1:0]       g;
        logic signed [ErrW-1:0] e;
        case (cnt_reg[1:0])
            2'd0:    begin g = cfg.gain_long;     e = ent_reg.e_long; end
            2'd1:    begin g = cfg.gain_lat;      e = ent_reg.e_lat;  end
            2'd2:    begin g = cfg.yaw_gain_long; e = ent_reg.e_yaw;  end
            2'd3:    begin g = cfg.yaw_gain_lat;  e = ent_reg.e_yaw;  end
            default: begin g = '0;                e = '0;             end
        endcase
        prod_next = $signed({1'b0, g}) * e;
    end

    // stage A: sum, round to Q1.14, clamp, zero while inactive
    always_comb
    begin
        logic                      is_y;
        logic signed [SumW-1:0]    base;
        logic signed [SumW-1:0]    yaw;
        logic signed [SumW-1:0]    sum;
        logic signed [SumW-1:0]    shifted;
        logic signed [SumW-1:0]    lim;
        is_y    = cnt_reg[OutIdxW-1];
        base    = SumW'(is_y ? prod_reg[1] : prod_reg[0]);
        yaw     = SumW'(is_y ? prod_reg[3] : prod_reg[2]);
        sum     = yaw_negative(cnt_reg) ? base - yaw : base + yaw;
        shifted = (sum + SumW'(1 << (RoundShift - 1))) >>> RoundShift;
        lim     = $signed(SumW'(is_y ? cfg.limit_lat : cfg.limit_long));
        if (shifted > lim)
        begin
            shifted = lim;
        end
        else if (shifted < -lim)
        begin
            shifted = -lim;
        end
        d_next = ent_reg.active ? shifted[DeltaW-1:0] : '0;
    end

    // stage B: the two filter products
    always_comb
    begin
        logic [GainW:0] inv_alpha;
        inv_alpha = 17'h10000 - {1'b0, cfg.filter_alpha};
        m1_next   = st_reg[ka_reg] * $signed({1'b0, inv_alpha});
        m2_next   = $signed({1'b0, cfg.filter_alpha}) * d_reg;
    end

    // stage C: accumulate, round, new state and output
    always_comb
    begin
        logic signed [50:0] acc;
        logic signed [32:0] t;
        acc    = 51'(m1_reg) + (51'(m2_reg) <<< 16) + 51'sd32768;
        f_next = acc[47:16];
        t      = 33'(f_next) + 33'sd32768;
        o_next = t[31:16];
    end

    // filter state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumOut; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (vb_reg)
        begin
            st_reg[kb_reg] <= f_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= q_data;
        end
        if (prod_en)
        begin
            prod_reg[cnt_reg[1:0]] <= prod_next;
        end
        if (issue)
        begin
            d_reg  <= d_next;
            ka_reg <= cnt_reg;
        end
        if (va_reg)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            kb_reg <= ka_reg;
        end
        if (vb_reg)
        begin
            dout_reg[kb_reg] <= o_next;
        end
    end

endmodule

// File: rtl/legged_push_recovery_deltas_top.sv
// legged_push_recovery_deltas_top: top level of the push-recovery foot
// displacement block. Depends on lprd_pkg, lprd_front, lprd_queue, lprd_back.
`timescale 1ns / 1ps

// Each beat carries desired and measured velocities and yaw rates; one result
// beat with eight filtered leg displacements follows. The front end places an
// accepted beat in a two-entry queue, so it keeps accepting while the back end
// works or a result waits, until the queue is full. The back end pops a beat,
// forms the four gain products on one shared multiplier, feeds the eight filter
// channels through a three-stage pipeline and lets the pipeline drain. It starts
// the next beat once the previous result has been taken. Register writes are
// taken in any cycle but must only be issued while the block holds no beat in
// flight.
module legged_push_recovery_deltas_top
    import lprd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CfgIdxW-1:0]        cfg_index,
    input  logic [CfgW-1:0]           cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VelW-1:0]    desired_vel_long,
    input  logic signed [VelW-1:0]    desired_vel_lat,
    input  logic signed [VelW-1:0]    desired_yaw_rate,
    input  logic signed [VelW-1:0]    measured_vel_long,
    input  logic signed [VelW-1:0]    measured_vel_lat,
    input  logic signed [VelW-1:0]    measured_yaw_rate,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DeltaW-1:0]  delta_x_leg0,
    output logic signed [DeltaW-1:0]  delta_x_leg1,
    output logic signed [DeltaW-1:0]  delta_x_leg2,
    output logic signed [DeltaW-1:0]  delta_x_leg3,
    output logic signed [DeltaW-1:0]  delta_y_leg0,
    output logic signed [DeltaW-1:0]  delta_y_leg1,
    output logic signed [DeltaW-1:0]  delta_y_leg2,
    output logic signed [DeltaW-1:0]  delta_y_leg3,
    output logic                      recovery_active
);

    lprd_cfg_t                     cfg;
    lprd_entry_t                   push_data;
    lprd_entry_t                   pop_data;
    lprd_q_status_t                q_stat;
    lprd_back_status_t             b_stat;
    logic                          push;
    logic                          pop;
    logic [NumOut-1:0][DeltaW-1:0] dout;

    lprd_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .desired_vel_long  (desired_vel_long),
        .desired_vel_lat   (desired_vel_lat),
        .desired_yaw_rate  (desired_yaw_rate),
        .measured_vel_long (measured_vel_long),
        .measured_vel_lat  (measured_vel_lat),
        .measured_yaw_rate (measured_yaw_rate),
        .q_full            (q_stat.full),
        .push              (push),
        .push_data         (push_data),
        .cfg               (cfg)
    );

    lprd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_stat)
    );

    lprd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_empty    (q_stat.empty),
        .q_data     (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dout       (dout),
        .active_out (recovery_active),
        .status     (b_stat)
    );

    // output fields: x legs first, then y legs
    assign delta_x_leg0 = $signed(dout[0]);
    assign delta_x_leg1 = $signed(dout[1]);
    assign delta_x_leg2 = $signed(dout[2]);
    assign delta_x_leg3 = $signed(dout[3]);
    assign delta_y_leg0 = $signed(dout[4]);
    assign delta_y_leg1 = $signed(dout[5]);
    assign delta_y_leg2 = $signed(dout[6]);
    assign delta_y_leg3 = $signed(dout[7]);

    // an accepted beat is held in the queue on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !q_stat.empty)
        else $error("accepted beat missing from queue");

    // the back end never works while a result is still held
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(b_stat.busy && out_valid))
        else $error("back end busy while result pending");

    // a result only appears at the end of back end work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(b_stat.done))
        else $error("result raised without completed work");

    // queue fill never passes its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCntW'(QDepth))
        else $error("queue overflow");

endmodule

// File: tb/sv/lprd_delta_checker.sv
// lprd_delta_checker: watches the register writes and both beat channels of the
// push-recovery displacement block, predicts every result beat and compares it.
// Depends on lprd_pkg.
`timescale 1ns / 1ps

module lprd_delta_checker
    import lprd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CfgIdxW-1:0]       cfg_index,
    input  logic [CfgW-1:0]          cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic signed [VelW-1:0]   desired_vel_long,
    input  logic signed [VelW-1:0]   desired_vel_lat,
    input  logic signed [VelW-1:0]   desired_yaw_rate,
    input  logic signed [VelW-1:0]   measured_vel_long,
    input  logic signed [VelW-1:0]   measured_vel_lat,
    input  logic signed [VelW-1:0]   measured_yaw_rate,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DeltaW-1:0] delta_x_leg0,
    input  logic signed [DeltaW-1:0] delta_x_leg1,
    input  logic signed [DeltaW-1:0] delta_x_leg2,
    input  logic signed [DeltaW-1:0] delta_x_leg3,
    input  logic signed [DeltaW-1:0] delta_y_leg0,
    input  logic signed [DeltaW-1:0] delta_y_leg1,
    input  logic signed [DeltaW-1:0] delta_y_leg2,
    input  logic signed [DeltaW-1:0] delta_y_leg3,
    input  logic                     recovery_active,
    output int                       mismatches,
    output int                       pending
);

    // legs whose yaw term is subtracted: x on legs 0 and 2, y on legs 2 and 3
    localparam logic [NumLegs-1:0] YawNegX = 4'b0101;
    localparam logic [NumLegs-1:0] YawNegY = 4'b1100;

    typedef struct packed {
        logic [NumLegs-1:0][DeltaW-1:0] dx;
        logic [NumLegs-1:0][DeltaW-1:0] dy;
        logic                           active;
    } leg_deltas_t;

    lprd_cfg_t   cfg;
    logic        active_flag;
    int          filt_x [NumLegs];
    int          filt_y [NumLegs];
    leg_deltas_t expected_deltas [$];
    int          beat_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns result beat %0d: %s", $time, beat_count, msg);
        mismatches++;
    endtask

    // outside +/-10.0 in Q5.11; exactly 10.0 is still in range
    function automatic logic beyond_ten(input logic signed [VelW-1:0] v);
        return (int'(v) > int'(VelLimit)) || (int'(v) < -int'(VelLimit));
    endfunction

    // Q.25 sum rounded to Q1.14, then clamped to +/-lim
    function automatic longint clamp_displacement(input longint acc, input longint lim);
        longint d;
        d = (acc + (longint'(1) <<< (RoundShift - 1))) >>> RoundShift;
        if (d > lim)
            d = lim;
        if (d < -lim)
            d = -lim;
        return d;
    endfunction

    // one low-pass step; returns the new Q1.30 state before truncation
    function automatic longint lowpass(input int st, input longint d);
        longint a;
        a = longint'(cfg.filter_alpha);
        return (longint'(st) * (65536 - a) + a * d * 65536 + 32768) >>> 16;
    endfunction

    function automatic leg_deltas_t predict_displacements(
        input logic signed [VelW-1:0] dvl, input logic signed [VelW-1:0] dvt,
        input logic signed [VelW-1:0] dyr, input logic signed [VelW-1:0] mvl,
        input logic signed [VelW-1:0] mvt, input logic signed [VelW-1:0] myr);
        leg_deltas_t res;
        longint      px, py, yx, yy, dx, dy, f;
        int          k;
        if (beyond_ten(dvl) || beyond_ten(dvt) || beyond_ten(dyr) ||
            beyond_ten(mvl) || beyond_ten(mvt) || beyond_ten(myr))
            active_flag = 1'b0;
        px = longint'(cfg.gain_long) * (longint'(mvl) - longint'(dvl));
        py = longint'(cfg.gain_lat) * (longint'(mvt) - longint'(dvt));
        yx = longint'(cfg.yaw_gain_long) * (longint'(myr) - longint'(dyr));
        yy = longint'(cfg.yaw_gain_lat) * (longint'(myr) - longint'(dyr));
        for (k = 0; k < NumLegs; k++)
        begin
            dx = 0;
            dy = 0;
            if (active_flag)
            begin
                dx = clamp_displacement(YawNegX[k] ? px - yx : px + yx,
                                        longint'(cfg.limit_long));
                dy = clamp_displacement(YawNegY[k] ? py - yy : py + yy,
                                        longint'(cfg.limit_lat));
            end
            f = lowpass(filt_x[k], dx);
            filt_x[k] = int'(f);
            res.dx[k] = DeltaW'((f + 32768) >>> 16);
            f = lowpass(filt_y[k], dy);
            filt_y[k] = int'(f);
            res.dy[k] = DeltaW'((f + 32768) >>> 16);
        end
        res.active = active_flag;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        leg_deltas_t want;
        leg_deltas_t got;
        int          k;
        if (!rst_n)
        begin
            cfg.gain_long     = '0;
            cfg.gain_lat      = '0;
            cfg.yaw_gain_long = '0;
            cfg.yaw_gain_lat  = '0;
            cfg.limit_long    = LimitReset;
            cfg.limit_lat     = LimitReset;
            cfg.filter_alpha  = '0;
            active_flag       = 1'b0;
            for (k = 0; k < NumLegs; k++)
            begin
                filt_x[k] = 0;
                filt_y[k] = 0;
            end
            expected_deltas.delete();
            beat_count = 0;
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_deltas.size() == 0)
                    report_mismatch("result beat with no input beat pending");
                else
                begin
                    want = expected_deltas.pop_front();
                    got.dx = {delta_x_leg3, delta_x_leg2, delta_x_leg1, delta_x_leg0};
                    got.dy = {delta_y_leg3, delta_y_leg2, delta_y_leg1, delta_y_leg0};
                    got.active = recovery_active;
                    for (k = 0; k < NumLegs; k++)
                    begin
                        if (got.dx[k] !== want.dx[k])
                            report_mismatch($sformatf("delta_x_leg%0d expected %0d got %0d",
                                k, $signed(want.dx[k]), $signed(got.dx[k])));
                        if (got.dy[k] !== want.dy[k])
                            report_mismatch($sformatf("delta_y_leg%0d expected %0d got %0d",
                                k, $signed(want.dy[k]), $signed(got.dy[k])));
                    end
                    if (got.active !== want.active)
                        report_mismatch($sformatf("recovery_active expected %0b got %b",
                            want.active, got.active));
                end
                beat_count++;
            end

            // register write mirror
            if (cfg_we)
            begin
                case (lprd_reg_idx_t'(cfg_index))
                    REG_ENABLE:        active_flag = cfg_data[0];
                    REG_GAIN_LONG:     cfg.gain_long = cfg_data;
                    REG_GAIN_LAT:      cfg.gain_lat = cfg_data;
                    REG_YAW_GAIN_LONG: cfg.yaw_gain_long = cfg_data;
                    REG_YAW_GAIN_LAT:  cfg.yaw_gain_lat = cfg_data;
                    REG_LIMIT_LONG:    cfg.limit_long = cfg_data[LimitW-1:0];
                    REG_LIMIT_LAT:     cfg.limit_lat = cfg_data[LimitW-1:0];
                    REG_FILTER_ALPHA:  cfg.filter_alpha = cfg_data;
                    default: ;
                endcase
            end

            // input beat: predict its result
            if (in_valid && in_ready)
                expected_deltas.push_back(predict_displacements(
                    desired_vel_long, desired_vel_lat, desired_yaw_rate,
                    measured_vel_long, measured_vel_lat, measured_yaw_rate));

            pending <= expected_deltas.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
// testbench: drives register writes and velocity beats into the push-recovery
// displacement block with random idling and back-pressure; the verdict comes
// from lprd_delta_checker. Depends on lprd_pkg, the block RTL and the checker.
`timescale 1ns / 1ps

module testbench;
    import lprd_pkg::*;

    localparam int QuietLimit   = 4000;
    localparam int DrainCycles  = 40;
    localparam int LongHold     = 400;
    localparam int RandomPhases = 10;
    localparam int PhaseBeats   = 150;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CfgIdxW-1:0]       cfg_index;
    logic [CfgW-1:0]          cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [VelW-1:0]   desired_vel_long;
    logic signed [VelW-1:0]   desired_vel_lat;
    logic signed [VelW-1:0]   desired_yaw_rate;
    logic signed [VelW-1:0]   measured_vel_long;
    logic signed [VelW-1:0]   measured_vel_lat;
    logic signed [VelW-1:0]   measured_yaw_rate;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DeltaW-1:0] delta_x_leg0;
    logic signed [DeltaW-1:0] delta_x_leg1;
    logic signed [DeltaW-1:0] delta_x_leg2;
    logic signed [DeltaW-1:0] delta_x_leg3;
    logic signed [DeltaW-1:0] delta_y_leg0;
    logic signed [DeltaW-1:0] delta_y_leg1;
    logic signed [DeltaW-1:0] delta_y_leg2;
    logic signed [DeltaW-1:0] delta_y_leg3;
    logic                     recovery_active;
    int                       mismatches;
    int                       pending;
    int                       quiet_cycles;
    logic                     hold_request;

    legged_push_recovery_deltas_top DUT (.*);

    lprd_delta_checker checker_i (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog: cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QuietLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // drop valid, then wait until every predicted result beat has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // write enable stays high; the caller lowers it after the last write
    task automatic set_register(input lprd_reg_idx_t idx, input logic [CfgW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(
        input logic [CfgW-1:0] en, input logic [CfgW-1:0] g_long,
        input logic [CfgW-1:0] g_lat, input logic [CfgW-1:0] yg_long,
        input logic [CfgW-1:0] yg_lat, input logic [CfgW-1:0] lim_long,
        input logic [CfgW-1:0] lim_lat, input logic [CfgW-1:0] alpha);
        settle();
        set_register(REG_GAIN_LONG, g_long);
        set_register(REG_GAIN_LAT, g_lat);
        set_register(REG_YAW_GAIN_LONG, yg_long);
        set_register(REG_YAW_GAIN_LAT, yg_lat);
        set_register(REG_LIMIT_LONG, lim_long);
        set_register(REG_LIMIT_LAT, lim_lat);
        set_register(REG_FILTER_ALPHA, alpha);
        set_register(REG_ENABLE, en);
        cfg_we <= 1'b0;
    endtask

    // offer one beat after the given idle gap; returns at the accepting edge
    task automatic send_beat(
        input logic signed [VelW-1:0] dvl, input logic signed [VelW-1:0] dvt,
        input logic signed [VelW-1:0] dyr, input logic signed [VelW-1:0] mvl,
        input logic signed [VelW-1:0] mvt, input logic signed [VelW-1:0] myr,
        input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        desired_vel_long  <= dvl;
        desired_vel_lat   <= dvt;
        desired_yaw_rate  <= dyr;
        measured_vel_long <= mvl;
        measured_vel_lat  <= mvt;
        measured_yaw_rate <= myr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic signed [VelW-1:0] in_range_vel(input int span);
        return VelW'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [CfgW-1:0] pick_setting(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0:       return CfgW'(lo);
            1:       return CfgW'(hi);
            default: return CfgW'($urandom_range(lo, hi));
        endcase
    endfunction

    // mostly in-range beats, large or near-equal pairs; rare noise and overrange
    task automatic random_beat(input int idx);
        logic signed [VelW-1:0] v [6];
        int                     r, j, gap;
        r = $urandom_range(0, 999);
        if (r < 480)
            for (j = 0; j < 6; j++)
                v[j] = in_range_vel(20480);
        else if (r < 990)
            for (j = 0; j < 3; j++)
            begin
                v[j]     = in_range_vel(20000);
                v[j + 3] = v[j] + in_range_vel(400);
            end
        else if (r < 995)
            for (j = 0; j < 6; j++)
                v[j] = VelW'($urandom);
        else
        begin
            for (j = 0; j < 6; j++)
                v[j] = in_range_vel(20480);
            j = $urandom_range(0, 5);
            if ($urandom_range(0, 1) == 1)
                v[j] = VelW'(int'($urandom_range(20481, 32767)));
            else
                v[j] = VelW'(-int'($urandom_range(20481, 32768)));
        end
        gap = ((idx % 50) < 10) ? 0 : $urandom_range(0, 9);
        send_beat(v[0], v[1], v[2], v[3], v[4], v[5], gap);
    endtask

    // result side: random stalls, bursts without stalls, one long hold-off
    initial
    begin
        int   gap;
        int   taken;
        logic held;
        out_ready = 1'b0;
        taken     = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
            end
            else
            begin
                gap = ((taken % 64) < 12) ? 0 : $urandom_range(0, 9);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
        end
    end

    // stimulus and verdict
    initial
    begin
        int   p, i;
        logic en_bit;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_ENABLE;
        cfg_data          = '0;
        in_valid          = 1'b0;
        desired_vel_long  = '0;
        desired_vel_lat   = '0;
        desired_yaw_rate  = '0;
        measured_vel_long = '0;
        measured_vel_lat  = '0;
        measured_yaw_rate = '0;
        hold_request      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: inactive, filter frozen
        send_beat(0, 0, 0, 0, 0, 0, 0);

        // enable through bit 0 only, unity gains, half yaw gains, fast filter
        load_settings(16'h0003, 16384, 16384, 8192, 8192, 1638, 1638, 65535);
        send_beat(0, 0, 0, 0, 0, 0, $urandom_range(0, 9));
        send_beat(20480, 20480, 20480, 20480, 20480, 20480, $urandom_range(0, 9));
        send_beat(-20480, -20480, -20480, 20480, 20480, 20480, $urandom_range(0, 9));
        send_beat(20480, 20480, 20480, -20480, -20480, -20480, $urandom_range(0, 9));
        send_beat(0, 0, -2048, 0, 0, 2048, $urandom_range(0, 9));
        send_beat(0, 0, 0, 100, -100, 50, $urandom_range(0, 9));
        send_beat(0, 0, 0, 0, 20481, 0, $urandom_range(0, 9));
        send_beat(0, 0, 0, 300, 300, 300, $urandom_range(0, 9));
        send_beat(-32768, 32767, -32768, 32767, -32768, 32767, $urandom_range(0, 9));

        // zero limit on x, widest limit on y, filter holding its state
        load_settings(16'h0001, 65535, 65535, 65535, 65535, 0, 32767, 0);
        send_beat(-20480, -20480, -20480, 20480, 20480, 20480, $urandom_range(0, 9));
        send_beat(0, 0, -20481, 0, 0, 0, $urandom_range(0, 9));

        // disabled with upper data bits set, outputs decay
        load_settings(16'hFFFE, 65535, 65535, 65535, 65535, 32767, 32767, 32768);
        send_beat(0, 0, 0, 1000, 1000, 1000, $urandom_range(0, 9));
        send_beat(0, 0, 0, 1000, 1000, 1000, $urandom_range(0, 9));

        // everything at its maximum
        load_settings(16'h0001, 65535, 65535, 65535, 65535, 32767, 32767, 65535);
        send_beat(-20480, -20480, 20480, 20480, 20480, -20480, $urandom_range(0, 9));
        send_beat(20480, 20480, -20480, -20480, -20480, 20480, $urandom_range(0, 9));

        for (p = 0; p < RandomPhases; p++)
        begin
            en_bit = (p != 3);
            if (p == 0)
                load_settings({15'($urandom), en_bit}, 65535, 65535, 65535, 65535,
                              32767, 32767, 65535);
            else if (p == 1)
                load_settings({15'($urandom), en_bit}, 0, 0, 0, 0, 1, 1, 0);
            else
                load_settings({15'($urandom), en_bit}, pick_setting(0, 65535),
                              pick_setting(0, 65535), pick_setting(0, 65535),
                              pick_setting(0, 65535), pick_setting(1, 32767),
                              pick_setting(1, 32767), pick_setting(0, 65535));
            for (i = 0; i < PhaseBeats; i++)
            begin
                if (p == 2 && i == 20)
                    hold_request = 1'b1;
                // drain midway and re-arm the flag a range error may have cleared
                if (i == PhaseBeats / 2)
                begin
                    settle();
                    set_register(REG_ENABLE, {15'($urandom), en_bit});
                    cfg_we <= 1'b0;
                end
                random_beat(i);
            end
        end

        settle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/lprd_pkg.sv
rtl/lprd_front.sv
rtl/lprd_queue.sv
rtl/lprd_back.sv
rtl/legged_push_recovery_deltas_top.sv
tb/sv/lprd_delta_checker.sv
tb/sv/testbench.sv
